// File: design/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, sizes and codes for the best-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

  // Heap geometry.
  localparam int HEAP_BYTES   = 65536;
  localparam int ALIGN_BYTES  = 16;
  localparam int HEADER_BYTES = 24;
  localparam int GRANULES     = HEAP_BYTES / ALIGN_BYTES;
  localparam int GW           = $clog2(GRANULES);
  localparam int AW           = $clog2(ALIGN_BYTES);
  localparam int AMASK        = ALIGN_BYTES - 1;
  localparam int USER_OFS     = (HEADER_BYTES + 1 + AMASK) & ~AMASK;
  localparam int PAD_BYTES    = USER_OFS - HEADER_BYTES;
  localparam int SZW          = 17;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_DOUBLE   = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_HEAP_SIZE = 1'b1;

  // Action codes.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // One header record per granule.
  typedef struct packed {
    logic           live;
    logic           is_free;
    logic           has_next;
    logic [GW-1:0]  next;
    logic [SZW-1:0] size;
  } hdr_t;

  // Heap setup derived from the configuration registers.
  typedef struct packed {
    logic           heap_ok;
    logic [31:0]    abase;
    logic [SZW-1:0] span;
  } heap_cfg_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_EV,
    S_A_PLAN,
    S_A_WR_NG,
    S_A_WR_PREV,
    S_A_WR_BEST,
    S_F_RD,
    S_F_CHK,
    S_F_WRD,
    S_F_EV,
    S_F_WR_G,
    S_F_WR_R,
    S_F_WR_T
  } state_e;

endpackage

`default_nettype wire

// File: design/bfa_hdr_mem.sv
// ----------------------------------------------------------------------------
// bfa_hdr_mem
// Header store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_hdr_mem
  import bfa_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [GW-1:0] waddr_i,
  input  wire hdr_t          wdata_i,
  input  wire logic [GW-1:0] raddr_i,
  output hdr_t               rdata_o
);

  hdr_t mem_q [GRANULES];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer that walks the free list, splits, merges and relinks blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ctrl
  import bfa_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           init_i,
  input  wire heap_cfg_t      cfg_i,
  input  wire logic           start_i,
  input  wire logic           action_i,
  input  wire logic [SZW-1:0] request_bytes_i,
  input  wire logic [31:0]    user_address_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [2:0]          status_o,
  output logic [31:0]         granted_address_o,
  output logic [SZW-1:0]      granted_bytes_o,
  output logic [SZW-1:0]      bytes_available_o
);

  state_e state_q, state_d;

  logic [GW-1:0]  clr_q, clr_d;
  logic [GW-1:0]  head_q, head_d;
  logic           head_valid_q, head_valid_d;
  logic [SZW-1:0] fb_q, fb_d;

  logic [SZW-1:0] n_q, n_d;
  logic [GW-1:0]  cur_q, cur_d;
  logic [GW-1:0]  prev_q, prev_d;
  hdr_t           prev_data_q, prev_data_d;
  logic           hp_q, hp_d;

  logic           found_q, found_d;
  logic [SZW:0]   min_fit_q, min_fit_d;
  logic [GW-1:0]  best_q, best_d;
  logic [GW-1:0]  best_prev_q, best_prev_d;
  logic           best_hp_q, best_hp_d;
  hdr_t           best_prev_data_q, best_prev_data_d;
  hdr_t           best_data_q, best_data_d;
  logic [SZW-1:0] actual_q, actual_d;
  logic           split_q, split_d;
  logic [GW-1:0]  ng_q, ng_d;

  logic [SZW-1:0] h_q, h_d;
  logic [GW-1:0]  g_q, g_d;
  logic [SZW-1:0] gsize_q, gsize_d;
  logic [SZW:0]   end_q, end_d;
  logic           hl_q, hl_d, hr_q, hr_d;
  logic [GW-1:0]  left_q, left_d, right_q, right_d;
  logic [SZW-1:0] lsize_q, lsize_d, rsize_q, rsize_d;

  logic           done_q, done_d;
  logic [2:0]     st_q, st_d;
  logic [31:0]    addr_q, addr_d;
  logic [SZW-1:0] bytes_q, bytes_d;
  logic [SZW-1:0] avail_q, avail_d;

  logic           mem_we;
  logic [GW-1:0]  mem_waddr, mem_raddr;
  hdr_t           mem_wdata, rd;

  bfa_hdr_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  // Datapath temporaries.
  logic [SZW:0]      need;
  logic [SZW:0]      fit;
  logic              hit, better;
  logic [SZW:0]      hbest;
  logic [SZW+1:0]    nsum, nxt, act;
  logic              whole;
  logic [SZW+1-AW:0] ngw;
  logic [31:0]       rel, hfree;
  logic [SZW:0]      coff, lend;
  logic              mr, ml;
  logic [SZW-1:0]    tsize;

  always_comb begin
    need   = {1'b0, n_q} + (SZW+1)'(PAD_BYTES);
    fit    = {1'b0, rd.size} - need;
    hit    = need <= {1'b0, rd.size};
    better = hit && (fit < min_fit_q);
    hbest  = (SZW+1)'({best_q, {AW{1'b0}}});
    nsum   = (SZW+2)'(hbest) + (SZW+2)'(HEADER_BYTES) + (SZW+2)'(need) + (SZW+2)'(AMASK);
    nxt    = nsum & ~(SZW+2)'(AMASK);
    act    = nxt - (SZW+2)'(hbest) - (SZW+2)'(HEADER_BYTES);
    whole  = (act > (SZW+2)'(best_data_q.size)) ||
             (((SZW+2)'(best_data_q.size) - act) < (SZW+2)'(HEADER_BYTES));
    ngw    = nxt[SZW+1:AW];
    rel    = user_address_i - cfg_i.abase;
    hfree  = rel - 32'(USER_OFS);
    coff   = (SZW+1)'({cur_q, {AW{1'b0}}});
    lend   = coff + (SZW+1)'(HEADER_BYTES) + (SZW+1)'(rd.size);
    mr     = !hr_q && (coff == end_q);
    ml     = !mr && !hl_q && (lend == (SZW+1)'(h_q));
    tsize  = gsize_q + (hl_q ? lsize_q + SZW'(HEADER_BYTES) : '0)
                     + (hr_q ? rsize_q + SZW'(HEADER_BYTES) : '0);
  end

  // Next state, memory control and result capture.
  always_comb begin
    state_d = state_q;
    clr_d = clr_q; head_d = head_q; head_valid_d = head_valid_q; fb_d = fb_q;
    n_d = n_q; cur_d = cur_q; prev_d = prev_q; prev_data_d = prev_data_q; hp_d = hp_q;
    found_d = found_q; min_fit_d = min_fit_q; best_d = best_q; best_prev_d = best_prev_q;
    best_hp_d = best_hp_q; best_prev_data_d = best_prev_data_q; best_data_d = best_data_q;
    actual_d = actual_q; split_d = split_q; ng_d = ng_q;
    h_d = h_q; g_d = g_q; gsize_d = gsize_q; end_d = end_q;
    hl_d = hl_q; hr_d = hr_q; left_d = left_q; right_d = right_q;
    lsize_d = lsize_q; rsize_d = rsize_q;
    done_d = 1'b0; st_d = st_q; addr_d = addr_q; bytes_d = bytes_q; avail_d = avail_q;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = cur_q;

    unique case (state_q)
      // Sweep the header store, writing the initial block last.
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == '0 && cfg_i.heap_ok) begin
          mem_wdata.live    = 1'b1;
          mem_wdata.is_free = 1'b1;
          mem_wdata.size    = cfg_i.span - SZW'(HEADER_BYTES);
        end
        clr_d = clr_q - GW'(1);
        if (clr_q == '0) begin
          head_d       = '0;
          head_valid_d = cfg_i.heap_ok;
          fb_d         = cfg_i.heap_ok ? cfg_i.span - SZW'(HEADER_BYTES) : '0;
          state_d      = S_IDLE;
        end
      end
      // Take a request and run the early checks.
      S_IDLE: begin
        if (start_i) begin
          n_d = request_bytes_i;
          if (action_i == ACT_ALLOC) begin
            if (request_bytes_i == '0) begin
              done_d = 1'b1; st_d = ST_ZERO; addr_d = '0; bytes_d = '0; avail_d = fb_q;
            end else if (!cfg_i.heap_ok || !head_valid_q ||
                         ({1'b0, request_bytes_i} + (SZW+1)'(ALIGN_BYTES)) > {1'b0, fb_q}) begin
              done_d = 1'b1; st_d = ST_NO_SPACE; addr_d = '0; bytes_d = '0; avail_d = fb_q;
            end else begin
              cur_d = head_q; hp_d = 1'b0; found_d = 1'b0; min_fit_d = '1;
              state_d = S_A_RD;
            end
          end else begin
            if (!cfg_i.heap_ok || rel < 32'(USER_OFS) || hfree[AW-1:0] != '0 ||
                hfree >= 32'(cfg_i.span)) begin
              done_d = 1'b1; st_d = ST_INVALID; addr_d = '0; bytes_d = '0; avail_d = fb_q;
            end else begin
              h_d = hfree[SZW-1:0];
              g_d = hfree[GW+AW-1:AW];
              state_d = S_F_RD;
            end
          end
        end
      end
      // Allocation walk: fetch one free block.
      S_A_RD: begin
        mem_raddr = cur_q;
        state_d   = S_A_EV;
      end
      // Allocation walk: keep the tightest fit seen so far.
      S_A_EV: begin
        if (better) begin
          found_d = 1'b1; best_d = cur_q; best_prev_d = prev_q; best_hp_d = hp_q;
          best_prev_data_d = prev_data_q; best_data_d = rd; min_fit_d = fit;
        end
        prev_d = cur_q; prev_data_d = rd; hp_d = 1'b1; cur_d = rd.next;
        if ((better && fit == '0) || !rd.has_next) begin
          state_d = S_A_PLAN;
        end else begin
          state_d = S_A_RD;
        end
      end
      // Decide between a split and a whole-block grant.
      S_A_PLAN: begin
        if (!found_q || (!whole && ngw >= (SZW+2-AW)'(GRANULES))) begin
          done_d = 1'b1; st_d = ST_NO_SPACE; addr_d = '0; bytes_d = '0; avail_d = fb_q;
          state_d = S_IDLE;
        end else begin
          split_d  = !whole;
          ng_d     = ngw[GW-1:0];
          actual_d = whole ? best_data_q.size : act[SZW-1:0];
          if (!whole) begin
            state_d = S_A_WR_NG;
          end else begin
            if (!best_hp_q) begin
              head_d = best_data_q.next; head_valid_d = best_data_q.has_next;
            end
            state_d = best_hp_q ? S_A_WR_PREV : S_A_WR_BEST;
          end
        end
      end
      // Write the free remainder of a split.
      S_A_WR_NG: begin
        mem_we = 1'b1; mem_waddr = ng_q;
        mem_wdata.live = 1'b1; mem_wdata.is_free = 1'b1;
        mem_wdata.has_next = best_data_q.has_next; mem_wdata.next = best_data_q.next;
        mem_wdata.size = best_data_q.size - actual_q - SZW'(HEADER_BYTES);
        if (!best_hp_q) begin
          head_d = ng_q; head_valid_d = 1'b1;
        end
        fb_d = (fb_q >= SZW'(HEADER_BYTES)) ? fb_q - SZW'(HEADER_BYTES) : '0;
        state_d = best_hp_q ? S_A_WR_PREV : S_A_WR_BEST;
      end
      // Relink the predecessor of the chosen block.
      S_A_WR_PREV: begin
        mem_we = 1'b1; mem_waddr = best_prev_q; mem_wdata = best_prev_data_q;
        mem_wdata.next     = split_q ? ng_q : best_data_q.next;
        mem_wdata.has_next = split_q ? 1'b1 : best_data_q.has_next;
        state_d = S_A_WR_BEST;
      end
      // Mark the chosen block used and report the grant.
      S_A_WR_BEST: begin
        mem_we = 1'b1; mem_waddr = best_q;
        mem_wdata.live = 1'b1; mem_wdata.size = actual_q;
        fb_d = (fb_q >= actual_q) ? fb_q - actual_q : '0;
        done_d = 1'b1; st_d = ST_OK;
        addr_d = cfg_i.abase + 32'(hbest) + 32'(USER_OFS);
        bytes_d = actual_q; avail_d = fb_d;
        state_d = S_IDLE;
      end
      // Free: fetch the header of the given block.
      S_F_RD: begin
        mem_raddr = g_q;
        state_d   = S_F_CHK;
      end
      // Free: check the header and start the neighbor search.
      S_F_CHK: begin
        if (!rd.live) begin
          done_d = 1'b1; st_d = ST_INVALID; addr_d = '0; bytes_d = '0; avail_d = fb_q;
          state_d = S_IDLE;
        end else if (rd.is_free) begin
          done_d = 1'b1; st_d = ST_DOUBLE; addr_d = '0; bytes_d = '0; avail_d = fb_q;
          state_d = S_IDLE;
        end else begin
          gsize_d = rd.size;
          fb_d    = fb_q + rd.size;
          end_d   = (SZW+1)'(h_q) + (SZW+1)'(HEADER_BYTES) + (SZW+1)'(rd.size);
          cur_d = head_q; hp_d = 1'b0; hl_d = 1'b0; hr_d = 1'b0;
          state_d = head_valid_q ? S_F_WRD : S_F_WR_G;
        end
      end
      // Neighbor search: fetch one free block.
      S_F_WRD: begin
        mem_raddr = cur_q;
        state_d   = S_F_EV;
      end
      // Neighbor search: unlink a block that touches either end.
      S_F_EV: begin
        if (mr || ml) begin
          if (mr) begin
            hr_d = 1'b1; right_d = cur_q; rsize_d = rd.size;
          end else begin
            hl_d = 1'b1; left_d = cur_q; lsize_d = rd.size;
          end
          if (!hp_q) begin
            head_d = rd.next; head_valid_d = rd.has_next;
          end else begin
            prev_data_d          = prev_data_q;
            prev_data_d.next     = rd.next;
            prev_data_d.has_next = rd.has_next;
            mem_we = 1'b1; mem_waddr = prev_q; mem_wdata = prev_data_d;
          end
        end else begin
          prev_d = cur_q; prev_data_d = rd; hp_d = 1'b1;
        end
        cur_d = rd.next;
        if (rd.has_next && !(hl_d && hr_d)) begin
          state_d = S_F_WRD;
        end else begin
          state_d = S_F_WR_G;
        end
      end
      // Retire the freed header when it merges into its left neighbor.
      S_F_WR_G: begin
        mem_we = hl_q; mem_waddr = g_q; mem_wdata.size = gsize_q;
        state_d = S_F_WR_R;
      end
      // Retire the right neighbor's header when it merges.
      S_F_WR_R: begin
        mem_we = hr_q; mem_waddr = right_q; mem_wdata.size = rsize_q;
        state_d = S_F_WR_T;
      end
      // Write the merged block and push it at the list head.
      S_F_WR_T: begin
        mem_we = 1'b1; mem_waddr = hl_q ? left_q : g_q;
        mem_wdata.live = 1'b1; mem_wdata.is_free = 1'b1;
        mem_wdata.has_next = head_valid_q; mem_wdata.next = head_q;
        mem_wdata.size = tsize;
        fb_d = fb_q + (hl_q ? SZW'(HEADER_BYTES) : '0) + (hr_q ? SZW'(HEADER_BYTES) : '0);
        head_d = hl_q ? left_q : g_q; head_valid_d = 1'b1;
        done_d = 1'b1; st_d = ST_OK; addr_d = '0; bytes_d = '0; avail_d = fb_d;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase

    // A configuration write restarts the heap setup.
    if (init_i) begin
      state_d = S_CLEAR;
      clr_d   = '1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '1;
      head_q       <= '0;
      head_valid_q <= 1'b0;
      fb_q         <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      fb_q         <= fb_d;
      done_q       <= done_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    n_q <= n_d; cur_q <= cur_d; prev_q <= prev_d; prev_data_q <= prev_data_d; hp_q <= hp_d;
    found_q <= found_d; min_fit_q <= min_fit_d; best_q <= best_d;
    best_prev_q <= best_prev_d; best_hp_q <= best_hp_d;
    best_prev_data_q <= best_prev_data_d; best_data_q <= best_data_d;
    actual_q <= actual_d; split_q <= split_d; ng_q <= ng_d;
    h_q <= h_d; g_q <= g_d; gsize_q <= gsize_d; end_q <= end_d;
    hl_q <= hl_d; hr_q <= hr_d; left_q <= left_d; right_q <= right_d;
    lsize_q <= lsize_d; rsize_q <= rsize_d;
    st_q <= st_d; addr_q <= addr_d; bytes_q <= bytes_d; avail_q <= avail_d;
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign status_o          = st_q;
  assign granted_address_o = addr_q;
  assign granted_bytes_o   = bytes_q;
  assign bytes_available_o = avail_q;

endmodule

`default_nettype wire

// File: design/best_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_core
// Best-fit free-list heap allocator with coalescing of free neighbors.
// ----------------------------------------------------------------------------
// An allocation walks the free list, then plans and writes the headers; a
// free checks its header, searches the free list for neighbors and writes
// the merge; early rejects answer from idle. One header read per free block.
// Throughput: one request at a time; busy_o stays high until done_o pulses.
// Reset and every configuration write clear the 4096-entry header store
// with busy_o high. Results cannot be stalled by the receiver.
`default_nettype none

module best_fit_heap_allocator_core
  import bfa_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_idx_i,
  input  wire logic [31:0]    cfg_data_i,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire logic           action_i,
  input  wire logic [SZW-1:0] request_bytes_i,
  input  wire logic [31:0]    user_address_i,
  output logic                done_o,
  output logic [2:0]          status_o,
  output logic [31:0]         granted_address_o,
  output logic [SZW-1:0]      granted_bytes_o,
  output logic [SZW-1:0]      bytes_available_o
);

  logic [31:0]    base_q;
  logic [SZW-1:0] size_q;
  logic [AW-1:0]  off;
  logic [SZW-1:0] sz;
  heap_cfg_t      cfg;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      size_q <= SZW'(HEAP_BYTES);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEAP_BASE: base_q <= cfg_data_i;
        CFG_HEAP_SIZE: size_q <= cfg_data_i[SZW-1:0];
        default:       base_q <= base_q;
      endcase
    end
  end

  // Align the base and trim the size to the managed span.
  always_comb begin
    off         = AW'(~base_q + 32'd1);
    sz          = (size_q > SZW'(HEAP_BYTES)) ? SZW'(HEAP_BYTES) : size_q;
    cfg.abase   = (base_q + 32'(AMASK)) & ~32'(AMASK);
    cfg.heap_ok = sz > (SZW'(off) + SZW'(HEADER_BYTES));
    cfg.span    = sz - SZW'(off);
  end

  bfa_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .init_i            (cfg_we_i),
    .cfg_i             (cfg),
    .start_i           (start_i),
    .action_i          (action_i),
    .request_bytes_i   (request_bytes_i),
    .user_address_i    (user_address_i),
    .busy_o            (busy_o),
    .done_o            (done_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .granted_bytes_o   (granted_bytes_o),
    .bytes_available_o (bytes_available_o)
  );

endmodule

`default_nettype wire
